### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the json string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // utf-8 encoding constants
  localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF8_CONT    = 8'h80;
  localparam logic [7:0]  UTF8_MASK    = 8'h3F;

  // one decoded item: one to three results of the same request
  typedef struct packed {
    logic [1:0]      num;   // number of results, 1 to 3
    logic [1:0]      kind;
    logic [2:0][7:0] data;  // result bytes, first in slot 0
  } jsu_entry_t;

endpackage

### rtl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// Input channel: one raw text byte or an end-of-text mark per request.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_ended;

  modport source (output valid, output in_byte, output text_ended, input ready);
  modport sink   (input valid, input in_byte, input text_ended, output ready);
endinterface

### rtl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// Output channel: one decoded byte, done marker or error per request.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

### rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Scanner: tracks string and escape state and turns each input byte into
// an entry of zero to three results.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       text_ended_i,
  output logic       push_o,
  output jsu_entry_t entry_o
);

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_STR  = 3'd1;
  localparam logic [2:0] MODE_ESC  = 3'd2;
  localparam logic [2:0] MODE_HEX1 = 3'd3;
  localparam logic [2:0] MODE_HEX2 = 3'd4;
  localparam logic [2:0] MODE_HEX3 = 3'd5;
  localparam logic [2:0] MODE_HEX4 = 3'd6;

  logic [2:0]  mode_q, mode_d;
  logic [15:0] cp_q, cp_d;
  logic [15:0] cp_next;
  logic [3:0]  hex_val;
  logic        hex_ok;
  logic        has_result;

  // hex digit decode, either case
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hex_val = in_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_next = {cp_q[11:0], hex_val};

  // next state and result entry
  always_comb begin
    mode_d        = mode_q;
    cp_d          = cp_q;
    has_result    = 1'b0;
    entry_o.num   = 2'd1;
    entry_o.kind  = KIND_BYTE;
    entry_o.data  = '0;
    case (mode_q)
      MODE_STR: begin
        if (text_ended_i) begin
          mode_d       = MODE_IDLE;
          has_result   = 1'b1;
          entry_o.kind = KIND_ERR;
        end else if (in_byte_i == 8'h22) begin
          mode_d       = MODE_IDLE;
          has_result   = 1'b1;
          entry_o.kind = KIND_DONE;
        end else if (in_byte_i == 8'h5C) begin
          mode_d = MODE_ESC;
        end else begin
          has_result      = 1'b1;
          entry_o.data[0] = in_byte_i;
        end
      end
      MODE_ESC: begin
        if (text_ended_i) begin
          mode_d       = MODE_IDLE;
          has_result   = 1'b1;
          entry_o.kind = KIND_ERR;
        end else begin
          mode_d     = MODE_STR;
          has_result = 1'b1;
          case (in_byte_i)
            8'h22:   entry_o.data[0] = 8'h22;
            8'h5C:   entry_o.data[0] = 8'h5C;
            8'h2F:   entry_o.data[0] = 8'h2F;
            8'h62:   entry_o.data[0] = 8'h08;
            8'h66:   entry_o.data[0] = 8'h0C;
            8'h6E:   entry_o.data[0] = 8'h0A;
            8'h72:   entry_o.data[0] = 8'h0D;
            8'h74:   entry_o.data[0] = 8'h09;
            8'h75: begin
              cp_d       = '0;
              mode_d     = MODE_HEX1;
              has_result = 1'b0;
            end
            default: begin
              // unknown escape keeps the backslash
              entry_o.num     = 2'd2;
              entry_o.data[0] = 8'h5C;
              entry_o.data[1] = in_byte_i;
            end
          endcase
        end
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
        if (text_ended_i || !hex_ok) begin
          mode_d       = MODE_IDLE;
          has_result   = 1'b1;
          entry_o.kind = KIND_ERR;
        end else begin
          cp_d = cp_next;
          if (mode_q != MODE_HEX4) begin
            mode_d = mode_q + 3'd1;
          end else begin
            mode_d     = MODE_STR;
            has_result = 1'b1;
            // utf-8 encode of the code point
            if (cp_next < CP_ONE_LIMIT) begin
              entry_o.data[0] = cp_next[7:0];
            end else if (cp_next < CP_TWO_LIMIT) begin
              entry_o.num     = 2'd2;
              entry_o.data[0] = UTF8_LEAD2 | {3'd0, cp_next[10:6]};
              entry_o.data[1] = UTF8_CONT | ({2'd0, cp_next[5:0]} & UTF8_MASK);
            end else begin
              entry_o.num     = 2'd3;
              entry_o.data[0] = UTF8_LEAD3 | {4'd0, cp_next[15:12]};
              entry_o.data[1] = UTF8_CONT | ({2'd0, cp_next[11:6]} & UTF8_MASK);
              entry_o.data[2] = UTF8_CONT | ({2'd0, cp_next[5:0]} & UTF8_MASK);
            end
          end
        end
      end
      default: begin
        // idle: wait for the opening quote
        mode_d = MODE_IDLE;
        if (!text_ended_i) begin
          if (in_byte_i == 8'h22) begin
            mode_d = MODE_STR;
          end else begin
            has_result   = 1'b1;
            entry_o.kind = KIND_ERR;
          end
        end
      end
    endcase
  end

  assign push_o = accept_i && has_result;

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cp_q   <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cp_q   <= cp_d;
    end
  end

endmodule

### rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short first-in first-out queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  jsu_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output jsu_entry_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  jsu_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntFull);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Emitter: holds one entry and sends its results one per cycle while ready.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  jsu_entry_t q_data_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  jsu_entry_t cur_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic       send;

  assign out_valid_o = busy_q;
  assign out_byte_o  = cur_q.data[idx_q];
  assign kind_o      = cur_q.kind;
  assign last_o      = (idx_q == cur_q.num - 2'd1);
  assign send        = busy_q && out_ready_i;
  assign pop_o       = q_valid_i && (!busy_q || (send && last_o));

  // current entry
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
  end

  // result index and hold flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (send) begin
      if (last_o) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

### rtl/json_string_unescaper_unit.sv
// Path: a result is held in the queue, then in the emitter's entry register.
// Throughput: one request per cycle while each gives at most one result and
// the receiver is ready; a request giving two or three results holds the
// emitter until all are sent, and the queue between scanner and emitter absorbs the difference.
// Reset: asynchronous, active low; the scanner returns to idle and the queue
// and output are emptied.
// ----------------------------------------------------------------------------
// json_string_unescaper_unit
// Decodes a quoted json string byte stream into unescaped utf-8 bytes.
// ----------------------------------------------------------------------------
module json_string_unescaper_unit
  import jsu_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  logic       accept;
  logic       push;
  logic       full;
  logic       pop;
  logic       q_valid;
  jsu_entry_t push_data;
  jsu_entry_t q_data;

  // take a request whenever the queue has room
  assign in_i.ready = !full;
  assign accept     = in_i.valid && !full;

  // scanner
  jsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .in_byte_i    (in_i.in_byte),
    .text_ended_i (in_i.text_ended),
    .push_o       (push),
    .entry_o      (push_data)
  );

  // entry queue
  jsu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // emitter
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .kind_o      (out_o.kind),
    .last_o      (out_o.last)
  );

endmodule

### sim/jsu_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_scoreboard_pkg
// Predicts the decoded bytes, done markers and errors of the json string
// unescaper and checks the results that the block delivers, in order.
// ----------------------------------------------------------------------------
package jsu_scoreboard_pkg;
  import jsu_pkg::*;

  // text characters the scanner reacts to
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // control bytes the simple escapes stand for
  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  typedef enum logic [2:0] {
    SCAN_IDLE = 3'd0,
    SCAN_STR  = 3'd1,
    SCAN_ESC  = 3'd2,
    SCAN_HEX1 = 3'd3,
    SCAN_HEX2 = 3'd4,
    SCAN_HEX3 = 3'd5,
    SCAN_HEX4 = 3'd6
  } scan_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } jsu_result_t;

  class jsu_scoreboard;
    jsu_result_t  decoded_q[$];
    scan_mode_e   mode;
    logic [15:0]  code_point;
    int unsigned  errors;

    function new();
      mode       = SCAN_IDLE;
      code_point = '0;
      errors     = 0;
    endfunction

    function int unsigned pending();
      return decoded_q.size();
    endfunction

    function void emit(logic [7:0] data, logic [1:0] kind);
      jsu_result_t res;
      res.data = data;
      res.kind = kind;
      res.last = 1'b0;
      decoded_q.insert(decoded_q.size(), res);
    endfunction

    // advance the scanner by one request and queue what it yields
    function void note_request(logic [7:0] c, logic ended);
      int unsigned before_n;
      logic [3:0]  digit;
      logic        is_hex;
      logic [15:0] cp;
      before_n = decoded_q.size();
      if (mode == SCAN_IDLE) begin
        if (!ended) begin
          if (c == CH_QUOTE) mode = SCAN_STR;
          else emit(8'h00, KIND_ERR);
        end
      end else if (ended) begin
        // text ran out inside a string
        mode = SCAN_IDLE;
        emit(8'h00, KIND_ERR);
      end else if (mode == SCAN_STR) begin
        if (c == CH_QUOTE) begin
          mode = SCAN_IDLE;
          emit(8'h00, KIND_DONE);
        end else if (c == CH_BSLASH) begin
          mode = SCAN_ESC;
        end else begin
          emit(c, KIND_BYTE);
        end
      end else if (mode == SCAN_ESC) begin
        mode = SCAN_STR;
        case (c)
          CH_QUOTE:  emit(CH_QUOTE, KIND_BYTE);
          CH_BSLASH: emit(CH_BSLASH, KIND_BYTE);
          CH_SLASH:  emit(CH_SLASH, KIND_BYTE);
          CH_B:      emit(BYTE_BS, KIND_BYTE);
          CH_F:      emit(BYTE_FF, KIND_BYTE);
          CH_N:      emit(BYTE_LF, KIND_BYTE);
          CH_R:      emit(BYTE_CR, KIND_BYTE);
          CH_T:      emit(BYTE_TAB, KIND_BYTE);
          CH_U: begin
            code_point = '0;
            mode       = SCAN_HEX1;
          end
          default: begin
            // unknown escape passes through with its backslash
            emit(CH_BSLASH, KIND_BYTE);
            emit(c, KIND_BYTE);
          end
        endcase
      end else begin
        is_hex = 1'b1;
        digit  = '0;
        if (c >= 8'h30 && c <= 8'h39) digit = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) digit = 4'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) digit = 4'(c - 8'h41 + 8'd10);
        else is_hex = 1'b0;
        if (!is_hex) begin
          mode = SCAN_IDLE;
          emit(8'h00, KIND_ERR);
        end else begin
          code_point = {code_point[11:0], digit};
          if (mode != SCAN_HEX4) begin
            mode = scan_mode_e'(mode + 3'd1);
          end else begin
            // utf-8 encode, surrogates included
            cp   = code_point;
            mode = SCAN_STR;
            if (cp < CP_ONE_LIMIT) begin
              emit(cp[7:0], KIND_BYTE);
            end else if (cp < CP_TWO_LIMIT) begin
              emit(UTF8_LEAD2 | 8'(cp >> 6), KIND_BYTE);
              emit(UTF8_CONT | (cp[7:0] & UTF8_MASK), KIND_BYTE);
            end else begin
              emit(UTF8_LEAD3 | 8'(cp >> 12), KIND_BYTE);
              emit(UTF8_CONT | (8'(cp >> 6) & UTF8_MASK), KIND_BYTE);
              emit(UTF8_CONT | (cp[7:0] & UTF8_MASK), KIND_BYTE);
            end
          end
        end
      end
      if (decoded_q.size() > before_n) decoded_q[decoded_q.size() - 1].last = 1'b1;
    endfunction

    // compare one delivered result with the oldest prediction
    function void check_result(logic [7:0] data, logic [1:0] kind, logic last);
      jsu_result_t exp_res;
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result data=%02h kind=%0d last=%0b",
                 $time, data, kind, last);
        return;
      end
      exp_res = decoded_q.pop_front();
      if (data !== exp_res.data) begin
        errors++;
        $display("%0t: out_byte mismatch expected=%02h actual=%02h",
                 $time, exp_res.data, data);
      end
      if (kind !== exp_res.kind) begin
        errors++;
        $display("%0t: kind mismatch expected=%0d actual=%0d", $time, exp_res.kind, kind);
      end
      if (last !== exp_res.last) begin
        errors++;
        $display("%0t: last mismatch expected=%0b actual=%0b", $time, exp_res.last, last);
      end
    endfunction
  endclass

endpackage

### sim/json_string_unescaper_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescaper_unit_tb
// Feeds directed and random json string text through the unescaper with
// random gaps on both channels and checks every result against a predictor.
// ----------------------------------------------------------------------------
module json_string_unescaper_unit_tb;
  import jsu_pkg::*;
  import jsu_scoreboard_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_ITEMS   = 30;
  localparam int unsigned DRAIN_CYCLES  = 20;

  logic clk;
  logic rst_n;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned item_count;
  int unsigned cycle_count;

  jsu_scoreboard sb;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescaper_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // watch both channels, then the cycle limit
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_request(in_if.in_byte, in_if.text_ended);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.out_byte, out_if.kind, out_if.last);
    end
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // one request, held until taken; called and returns at a falling edge
  task automatic send_request(input logic [7:0] b, input logic ended);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid      = 1'b1;
    in_if.in_byte    = b;
    in_if.text_ended = ended;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    item_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
        (c >= 8'h41 && c <= 8'h46)) c = 8'h67;
    return c;
  endfunction

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(4))
      0: return 16'($urandom_range(16'h007F));
      1: return 16'($urandom_range(16'h07FF, 16'h0080));
      2: return 16'($urandom_range(16'hFFFF, 16'h0800));
      3: return 16'($urandom_range(16'hDFFF, 16'hD800));
      default: begin
        // encoding boundaries
        case ($urandom_range(5))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          3: return 16'h07FF;
          4: return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(7))
      0: return CH_QUOTE;
      1: return CH_BSLASH;
      2: return CH_SLASH;
      3: return CH_B;
      4: return CH_F;
      5: return CH_N;
      6: return CH_R;
      default: return CH_T;
    endcase
  endfunction

  // a quoted string with random content, sometimes broken at the end
  task automatic send_random_string();
    int unsigned n_tok;
    logic [7:0]  c;
    logic [15:0] cp;
    int unsigned n_dig;
    send_request(CH_QUOTE, 1'b0);
    n_tok = $urandom_range(6);
    repeat (n_tok) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          c = 8'($urandom_range(255));
          if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h41;
          send_request(c, 1'b0);
        end
        4, 5: begin
          send_request(CH_BSLASH, 1'b0);
          send_request(pick_escape(), 1'b0);
        end
        6: begin
          c = 8'($urandom_range(255));
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U: c = 8'h71;
            default: ;
          endcase
          send_request(CH_BSLASH, 1'b0);
          send_request(c, 1'b0);
        end
        default: begin
          cp = pick_code_point();
          send_request(CH_BSLASH, 1'b0);
          send_request(CH_U, 1'b0);
          for (int k = 3; k >= 0; k--) send_request(hex_char(cp[4*k +: 4]), 1'b0);
        end
      endcase
    end
    case ($urandom_range(9))
      0: send_request(8'($urandom_range(255)), 1'b1);
      1: begin
        send_request(CH_BSLASH, 1'b0);
        send_request(8'($urandom_range(255)), 1'b1);
      end
      2: begin
        // broken unicode escape
        send_request(CH_BSLASH, 1'b0);
        send_request(CH_U, 1'b0);
        n_dig = $urandom_range(3);
        repeat (n_dig) send_request(hex_char(4'($urandom_range(15))), 1'b0);
        if ($urandom_range(1)) send_request(8'($urandom_range(255)), 1'b1);
        else send_request(non_hex_byte(), 1'b0);
      end
      default: send_request(CH_QUOTE, 1'b0);
    endcase
  endtask

  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(4, 1);
    repeat (n) send_request(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  // main sequence
  initial begin
    int unsigned target;
    sb               = new();
    src_idle_pct     = 30;
    snk_idle_pct     = 67;
    item_count       = 0;
    cycle_count      = 0;
    in_if.valid      = 1'b0;
    in_if.in_byte    = 8'h00;
    in_if.text_ended = 1'b0;
    rst_n            = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: missing quote, end while idle, byte extremes, escapes,
    // unicode with mixed case and a surrogate, bad hex, truncation
    send_request(8'h78, 1'b0);
    send_request(8'h00, 1'b1);
    send_text("\"");
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_text("\\n\\q\\u00e9\\uDfFf\"");
    send_text("\"\\u1g");
    send_text("\"");
    send_request(8'hFF, 1'b1);

    // random phases with different stall patterns
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 30;
          snk_idle_pct = 67;
        end
        1: begin
          src_idle_pct = 67;
          snk_idle_pct = 30;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      target = item_count + PHASE_ITEMS;
      while (item_count < target) begin
        if ($urandom_range(9) < 8) send_random_string();
        else send_noise();
      end
    end
    in_if.valid = 1'b0;

    // drain
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescaper_unit.sv
sim/jsu_scoreboard_pkg.sv
sim/json_string_unescaper_unit_tb.sv
